// ----- hw/rtl/rth_pkg.sv -----
package rth_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned ChanW    = FracBits + 1;
  localparam int unsigned HueW     = FracBits;
  localparam int unsigned SumW     = ChanW + 1;
  localparam int unsigned NumW     = ChanW + 3;
  localparam int unsigned QuotW    = FracBits + 1;
  localparam logic [ChanW-1:0] One = ChanW'(1) << FracBits;

  localparam logic [1:0] MaxRed   = 2'd0;
  localparam logic [1:0] MaxGreen = 2'd1;
  localparam logic [1:0] MaxBlue  = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] lightness;
  } hsl_t;

  // one restoring division stage
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [NumW-1:0]  den;
    logic [QuotW-1:0] quo;
  } div_t;

  // shared stage of both dividers
  function automatic div_t div_step(div_t s);
    div_t o;
    logic [NumW:0] r2;
    o = s;
    r2 = {s.rem, 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      o.rem = NumW'(r2 - {1'b0, s.den});
      o.quo = {s.quo[QuotW-2:0], 1'b1};
    end else begin
      o.rem = NumW'(r2);
      o.quo = {s.quo[QuotW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/rth_if.sv -----
interface rth_rgb_if;
  import rth_pkg::*;
  logic valid;
  logic ready;
  rgb_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rth_hsl_if;
  import rth_pkg::*;
  logic valid;
  logic ready;
  hsl_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rgb_to_hsl_top.sv -----
// rgb to hsl converter: takes one pixel per clock while not stalled and returns
// hue, saturation and lightness through one front stage, sixteen divider stages
// that each produce one quotient bit of both quotients, and one output register.
// The whole pipeline advances when the output register is empty or taken, so
// back pressure stalls it without losing or repeating a transfer.
module rgb_to_hsl_top import rth_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  rth_rgb_if.sink   pix_i,
  rth_hsl_if.source hsl_o
);

  logic             en, f_valid, d_valid, grey;
  div_t             sat_s, hue_s;
  logic [ChanW-1:0] lit;
  hsl_t             res;
  logic             out_valid_q;
  hsl_t             out_q;

  assign en        = !out_valid_q || hsl_o.ready;
  assign pix_i.ready = en;

  rth_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pix_i.valid), .pix_i(pix_i.data),
    .valid_o(f_valid), .sat_o(sat_s), .hue_o(hue_s), .grey_o(grey), .lit_o(lit)
  );

  rth_div_pipe u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .sat_i(sat_s), .hue_i(hue_s),
    .grey_i(grey), .lit_i(lit), .valid_o(d_valid), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign hsl_o.valid = out_valid_q;
  assign hsl_o.data  = out_q;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_o.valid && !hsl_o.ready |=> hsl_o.valid && $stable(hsl_o.data))
    else $error("stalled result changed");
  // input ready follows output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready == (!hsl_o.valid || hsl_o.ready))
    else $error("ready mismatch");
  // a result with zero saturation has zero hue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsl_o.valid && hsl_o.data.saturation == '0 |-> hsl_o.data.hue == '0)
    else $error("hue without saturation");

endmodule

// ----- hw/rtl/rth_front.sv -----
// clamp, max/min, numerators and denominators, one register stage
module rth_front import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rgb_t             pix_i,
  output logic             valid_o,
  output div_t             sat_o,
  output div_t             hue_o,
  output logic             grey_o,
  output logic [ChanW-1:0] lit_o
);

  logic [ChanW-1:0] r, g, b, mx, mn, dl;
  logic [SumW-1:0]  sum, den;
  logic [NumW-1:0]  n, d6;
  logic             sat_full;
  logic             valid_q, grey_q;
  div_t             sat_q, hue_q;
  logic [ChanW-1:0] lit_q;

  always_comb begin
    r = (pix_i.red   > One) ? One : pix_i.red;
    g = (pix_i.green > One) ? One : pix_i.green;
    b = (pix_i.blue  > One) ? One : pix_i.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl  = mx - mn;
    sum = SumW'(mx) + SumW'(mn);
    den = (sum < SumW'(One)) ? sum : (SumW'({One, 1'b0}) - sum);
    // delta equals den when one channel is zero or at full scale
    sat_full = (NumW'(dl) >= NumW'(den));
    d6  = NumW'(dl) * NumW'(6);
    // hue numerator, wrapped into [0, 6*delta)
    if (r >= mx)      n = NumW'(g) - NumW'(b);
    else if (g >= mx) n = (NumW'(dl) << 1) + NumW'(b) - NumW'(r);
    else              n = (NumW'(dl) << 2) + NumW'(r) - NumW'(g);
    if (n[NumW-1]) n = n + d6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // saturation integer bit is resolved here since delta <= den,
  // the hue quotient has none since n < 6*delta
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q.rem <= sat_full ? '0 : NumW'(dl);
      sat_q.den <= NumW'(den);
      sat_q.quo <= sat_full ? QuotW'(1) : '0;
      hue_q.rem <= n;
      hue_q.den <= d6;
      hue_q.quo <= '0;
      grey_q    <= (dl == '0);
      lit_q     <= ChanW'(sum >> 1);
    end
  end

  assign valid_o = valid_q;
  assign sat_o   = sat_q;
  assign hue_o   = hue_q;
  assign grey_o  = grey_q;
  assign lit_o   = lit_q;

endmodule

// ----- hw/rtl/rth_div_pipe.sv -----
// restoring dividers for saturation and hue, one quotient bit per stage
module rth_div_pipe import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_t             sat_i,
  input  div_t             hue_i,
  input  logic             grey_i,
  input  logic [ChanW-1:0] lit_i,
  output logic             valid_o,
  output hsl_t             res_o
);

  localparam int unsigned Stages = FracBits;

  logic [Stages-1:0] valid_q;
  div_t              sat_q [Stages];
  div_t              hue_q [Stages];
  logic [Stages-1:0] grey_q;
  logic [ChanW-1:0]  lit_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= div_step(sat_i);
      hue_q[0]  <= div_step(hue_i);
      grey_q[0] <= grey_i;
      lit_q[0]  <= lit_i;
      for (int i = 1; i < Stages; i++) begin
        sat_q[i]  <= div_step(sat_q[i-1]);
        hue_q[i]  <= div_step(hue_q[i-1]);
        grey_q[i] <= grey_q[i-1];
        lit_q[i]  <= lit_q[i-1];
      end
    end
  end

  // hue quotient is below 65536 since n < 6*delta
  always_comb begin
    res_o.lightness  = lit_q[Stages-1];
    res_o.saturation = grey_q[Stages-1] ? '0 : ChanW'(sat_q[Stages-1].quo);
    res_o.hue        = grey_q[Stages-1] ? '0 : HueW'(hue_q[Stages-1].quo);
  end
  assign valid_o = valid_q[Stages-1];

endmodule
